FILE: rtl/rgba_convolve_matrix_filter_defines.svh
// Assertion macros for the RGBA convolution filter checker.
// No dependencies; the checker includes this header by its bare name.
`ifndef RGBA_CONVOLVE_MATRIX_FILTER_DEFINES_SVH
`define RGBA_CONVOLVE_MATRIX_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RCMF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcmf: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RCMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcmf: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define RCMF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rcmf: reset check failed");

`endif

FILE: rtl/rcmf_pkg.sv
// Shared types and constants of the RGBA convolution filter.
// No dependencies; used by the top level and its checker.
package rcmf_pkg;

  // Transaction modes
  localparam logic [1:0] MODE_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_COEF    = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KORDER  = 3'd2;
  localparam logic [2:0] REG_TARGET  = 3'd3;
  localparam logic [2:0] REG_DIVISOR = 3'd4;
  localparam logic [2:0] REG_BIAS    = 3'd5;
  localparam logic [2:0] REG_FMODE   = 3'd6;

  // Edge modes
  localparam logic [1:0] EDGE_DUP  = 2'd1;
  localparam logic [1:0] EDGE_WRAP = 2'd2;

  // Channel indexes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  localparam int KDEPTH = 64;   // 8 x 8 kernel
  localparam int ACC_W  = 32;   // channel sum, 64 taps of 16 x 8 bits
  localparam int NUM_W  = 42;   // 256*sum + bias*divisor
  localparam int REM_W  = 32;   // divider remainder and shifted denominator

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_TAP   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_SRC   = 7'b0010000,
    ST_DLOAD = 7'b0100000,
    ST_DSTEP = 7'b1000000
  } state_t;

endpackage

FILE: rtl/rgba_convolve_matrix_filter.sv
// Top level of the RGBA convolution filter: frame store, kernel store,
// tap sequencer, multiply-accumulate lanes and shared divider. Uses rcmf_pkg.
//
// Load transactions (pixel or coefficient) leave busy low.
// A compute transaction walks the kernel one tap per cycle through the single
// read port of the frame store, then runs one restoring divider over the
// channels, one quotient bit per cycle. A prep state first folds the start
// position into the image for wrap mode. Four channels are divided (three
// when alpha is preserved). busy stays high throughout. The result is shown
// in the first cycle after busy falls, for exactly one cycle with out_valid,
// which the receiver must take as it comes; the next transaction may be
// taken in that same cycle.
// A compute at a position outside the configured image gives no result.
// Stores have no reset: read only entries that have been written.
module rgba_convolve_matrix_filter import rcmf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_column,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic [7:0]         in_alpha_in,
  input  logic [5:0]         in_coefficient_index,
  input  logic signed [15:0] in_coefficient_value,
  // result channel
  output logic               out_valid,
  output logic [7:0]         out_column,
  output logic [7:0]         out_row,
  output logic [7:0]         out_red_out,
  output logic [7:0]         out_green_out,
  output logic [7:0]         out_blue_out,
  output logic [7:0]         out_alpha_out,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW_X  = $clog2(MAX_WIDTH + 1);
  localparam int CW_Y  = $clog2(MAX_HEIGHT + 1);
  localparam int CW_XY = (CW_X > CW_Y) ? CW_X : CW_Y;
  localparam int CW    = (CW_XY > 9) ? CW_XY : 9;   // unsigned coordinate width
  localparam int SW    = CW + 1;                    // signed raw coordinate width
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [8:0]  width_r, height_r;
  logic [5:0]  korder_r, target_r;
  logic [15:0] divisor_r;
  logic [17:0] bias_r;
  logic [2:0]  fmode_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 9'd256;
      height_r  <= 9'd256;
      korder_r  <= 6'd18;
      target_r  <= 6'd9;
      divisor_r <= 16'd256;
      bias_r    <= '0;
      fmode_r   <= 3'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_WIDTH:   width_r   <= pwdata[8:0];
        REG_HEIGHT:  height_r  <= pwdata[8:0];
        REG_KORDER:  korder_r  <= pwdata[5:0];
        REG_TARGET:  target_r  <= pwdata[5:0];
        REG_DIVISOR: divisor_r <= pwdata[15:0];
        REG_BIAS:    bias_r    <= pwdata[17:0];
        REG_FMODE:   fmode_r   <= pwdata[2:0];
        default: ;   // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WIDTH:   prdata = {23'd0, width_r};
      REG_HEIGHT:  prdata = {23'd0, height_r};
      REG_KORDER:  prdata = {26'd0, korder_r};
      REG_TARGET:  prdata = {26'd0, target_r};
      REG_DIVISOR: prdata = {16'd0, divisor_r};
      REG_BIAS:    prdata = {14'd0, bias_r};
      REG_FMODE:   prdata = {29'd0, fmode_r};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Derived, busy-stable if user (unchecked) changes configuration only idle
  // ---------------------------------------------------------------------------
  logic [CW-1:0]      w_eff, h_eff;
  logic [2:0]         cols_m1, rows_m1, tx, ty;
  logic               dup, wrap, keep;
  logic signed [15:0] d_eff;
  logic signed [16:0] d_ext, d_mag;
  logic [23:0]        m_den;
  logic [6:0]         ktot;

  always_comb begin
    if (width_r == 9'd0)                      w_eff = CW'(1);
    else if (CW'(width_r) > CW'(MAX_WIDTH))   w_eff = CW'(MAX_WIDTH);
    else                                      w_eff = CW'(width_r);
    if (height_r == 9'd0)                     h_eff = CW'(1);
    else if (CW'(height_r) > CW'(MAX_HEIGHT)) h_eff = CW'(MAX_HEIGHT);
    else                                      h_eff = CW'(height_r);
  end

  assign cols_m1 = korder_r[2:0];
  assign rows_m1 = korder_r[5:3];
  assign tx      = target_r[2:0];
  assign ty      = target_r[5:3];
  assign dup     = (fmode_r[1:0] == EDGE_DUP);
  assign wrap    = (fmode_r[1:0] == EDGE_WRAP);
  assign keep    = fmode_r[2];
  assign ktot    = (7'(rows_m1) + 7'd1) * (7'(cols_m1) + 7'd1);

  // A zero divisor counts as one (256 in Q8.8); work with its magnitude
  assign d_eff = (divisor_r == 16'd0) ? 16'sd256 : $signed(divisor_r);
  assign d_ext = {d_eff[15], d_eff};
  assign d_mag = d_eff[15] ? -d_ext : d_ext;
  assign m_den = {d_mag[15:0], 8'd0};

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t              state_r;
  logic                accept, do_compute;
  logic [7:0]          col_r, row_r;
  logic [2:0]          i_r, j_r;
  logic [5:0]          kidx_r;
  logic signed [SW-1:0] x0_r, y0_r, xr_r, yr_r, wx0_r, wy0_r;
  logic [CW-1:0]       wx_r, wy_r;
  logic                tap_v_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic signed [33:0]  bd_r;
  logic [1:0]          ch_r;
  logic [7:0]          amax_r, src_alpha_r, q_r;
  logic [REM_W-1:0]    rem_r, msh_r;
  logic [2:0]          step_r;
  logic                neg_r, big_r;
  logic                out_valid_r;
  logic [7:0]          out_col_r, out_row_r, red_r, green_r, blue_r, alpha_r;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start & ~busy;
  assign do_compute = accept && (in_mode == MODE_COMPUTE)
                      && (CW'(in_column) < w_eff) && (CW'(in_row) < h_eff);

  // ---------------------------------------------------------------------------
  // Frame and kernel stores
  // ---------------------------------------------------------------------------
  logic [31:0]        frame_mem [DEPTH];
  logic signed [15:0] kern_mem [KDEPTH];
  logic [31:0]        frame_q;
  logic signed [15:0] coef_q;
  logic [AW-1:0]      wr_addr, rd_addr, tap_addr, tgt_addr;
  logic               pix_wr;

  assign pix_wr  = accept && (in_mode == MODE_PIXEL)
                   && (CW'(in_column) < CW'(MAX_WIDTH)) && (CW'(in_row) < CW'(MAX_HEIGHT));
  assign wr_addr = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_column);
  assign tgt_addr = AW'(row_r) * AW'(MAX_WIDTH) + AW'(col_r);

  always_ff @(posedge clk) begin
    if (pix_wr) begin
      frame_mem[wr_addr] <= {in_alpha_in, in_blue_in, in_green_in, in_red_in};
    end
    frame_q <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_mode == MODE_COEF)) begin
      kern_mem[in_coefficient_index] <= in_coefficient_value;
    end
    coef_q <= kern_mem[kidx_r];
  end

  // ---------------------------------------------------------------------------
  // Tap address: map the raw neighbour position by the edge mode
  // ---------------------------------------------------------------------------
  logic          x_in, y_in, tap_ok, last_col, last_tap;
  logic [CW-1:0] mx, my, wx_inc, wy_inc;

  always_comb begin
    x_in = (xr_r >= 0) && (xr_r < $signed({1'b0, w_eff}));
    y_in = (yr_r >= 0) && (yr_r < $signed({1'b0, h_eff}));
    if (x_in)     mx = xr_r[CW-1:0];
    else if (dup) mx = xr_r[SW-1] ? '0 : w_eff - CW'(1);
    else          mx = wx_r;
    if (y_in)     my = yr_r[CW-1:0];
    else if (dup) my = yr_r[SW-1] ? '0 : h_eff - CW'(1);
    else          my = wy_r;
    tap_ok   = (x_in | dup | wrap) & (y_in | dup | wrap);
    tap_addr = AW'(my) * AW'(MAX_WIDTH) + AW'(mx);
    last_col = (j_r == cols_m1);
    last_tap = last_col && (i_r == rows_m1);
    // wrapped coordinates step by one and roll over at the image edge
    wx_inc   = (wx_r + CW'(1) == w_eff) ? '0 : wx_r + CW'(1);
    wy_inc   = (wy_r + CW'(1) == h_eff) ? '0 : wy_r + CW'(1);
    rd_addr  = (state_r == ST_TAP) ? tap_addr : tgt_addr;
  end

  // ---------------------------------------------------------------------------
  // Multiply-accumulate lanes, one per channel
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      if (do_compute) begin
        acc_r[c] <= '0;
      end else if (tap_v_r) begin
        acc_r[c] <= acc_r[c]
                    + ACC_W'(25'(coef_q) * 25'($signed({1'b0, frame_q[8*c +: 8]})));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider operand: n = 256*sum + bias*divisor, signs folded into n
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] n_raw, n_val;
  logic [7:0]              q_fin, q_sat, q_lim, q_res;
  logic                    ge;

  always_comb begin
    n_raw = (NUM_W'(acc_r[ch_r]) <<< 8) + NUM_W'(bd_r);
    n_val = d_eff[15] ? -n_raw : n_raw;
    ge    = (rem_r >= msh_r);
    q_fin = {q_r[6:0], ge};
    if (neg_r)      q_sat = 8'd0;
    else if (big_r) q_sat = 8'd255;
    else            q_sat = q_fin;
    q_lim = (ch_r == CH_ALPHA) ? 8'd255 : amax_r;
    q_res = (q_sat > q_lim) ? q_lim : q_sat;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      tap_v_r     <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (do_compute) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          // fold the start position into the image for wrap mode
          if ((wx0_r >= 0) && (wy0_r >= 0)) begin
            state_r <= ST_TAP;
          end
        end
        ST_TAP: begin
          tap_v_r <= tap_ok;
          if (last_tap) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_r <= ST_SRC;
        ST_SRC:   state_r <= ST_DLOAD;
        ST_DLOAD: state_r <= ST_DSTEP;
        ST_DSTEP: begin
          if (step_r == 3'd0) begin
            if (ch_r == CH_BLUE) begin
              state_r     <= ST_IDLE;
              out_valid_r <= 1'b1;
            end else begin
              state_r <= ST_DLOAD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r  <= in_column;
        row_r  <= in_row;
        x0_r   <= $signed(SW'(in_column)) - $signed(SW'(tx));
        y0_r   <= $signed(SW'(in_row)) - $signed(SW'(ty));
        wx0_r  <= $signed(SW'(in_column)) - $signed(SW'(tx));
        wy0_r  <= $signed(SW'(in_row)) - $signed(SW'(ty));
        i_r    <= '0;
        j_r    <= '0;
        kidx_r <= 6'(ktot - 7'd1);     // flipped kernel: walk it backwards
        amax_r <= 8'd255;
        ch_r   <= keep ? CH_RED : CH_ALPHA;
      end
      ST_PREP: begin
        bd_r <= $signed(bias_r) * d_eff;
        if (wx0_r < 0) wx0_r <= wx0_r + $signed({1'b0, w_eff});
        if (wy0_r < 0) wy0_r <= wy0_r + $signed({1'b0, h_eff});
        xr_r <= x0_r;
        yr_r <= y0_r;
        wx_r <= wx0_r[CW-1:0];
        wy_r <= wy0_r[CW-1:0];
      end
      ST_TAP: begin
        kidx_r <= kidx_r - 6'd1;
        if (last_col) begin
          j_r  <= '0;
          i_r  <= i_r + 3'd1;
          xr_r <= x0_r;
          wx_r <= wx0_r[CW-1:0];
          yr_r <= yr_r + SW'(1);
          wy_r <= wy_inc;
        end else begin
          j_r  <= j_r + 3'd1;
          xr_r <= xr_r + SW'(1);
          wx_r <= wx_inc;
        end
      end
      ST_SRC: src_alpha_r <= frame_q[31:24];
      ST_DLOAD: begin
        neg_r  <= n_val[NUM_W-1];
        big_r  <= (n_val >= $signed({10'd0, m_den, 8'd0}));
        rem_r  <= n_val[REM_W-1:0];
        msh_r  <= {1'b0, m_den, 7'd0};
        q_r    <= '0;
        step_r <= 3'd7;
      end
      ST_DSTEP: begin
        // restoring step: one quotient bit per cycle
        if (ge) rem_r <= rem_r - msh_r;
        msh_r  <= msh_r >> 1;
        q_r    <= q_fin;
        step_r <= step_r - 3'd1;
        if (step_r == 3'd0) begin
          case (ch_r)
            CH_ALPHA: begin
              amax_r <= q_res;
              ch_r   <= CH_RED;
            end
            CH_RED: begin
              red_r <= q_res;
              ch_r  <= CH_GREEN;
            end
            CH_GREEN: begin
              green_r <= q_res;
              ch_r    <= CH_BLUE;
            end
            default: begin
              blue_r    <= q_res;
              alpha_r   <= keep ? src_alpha_r : amax_r;
              out_col_r <= col_r;
              out_row_r <= row_r;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_alpha_out = alpha_r;

endmodule

FILE: rtl/rcmf_checker.sv
// Port-level checker for the RGBA convolution filter, bound to the top level.
// Depends on rcmf_pkg and rgba_convolve_matrix_filter_defines.svh.
`include "rgba_convolve_matrix_filter_defines.svh"

module rcmf_checker import rcmf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_mode,
  input logic       out_valid
);

  // a result strobe lasts one cycle
  `RCMF_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // loads finish at once and never yield a result
  `RCMF_ASSERT_NEXT(a_load_quick, start && !busy && in_mode != MODE_COMPUTE, !busy && !out_valid)
  // a result only closes a busy compute transaction
  `RCMF_ASSERT_IMPLY(a_result_after_busy, out_valid, !busy && $past(busy))
  // reset leaves the block idle with no result
  `RCMF_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !busy && !out_valid)

endmodule

bind rgba_convolve_matrix_filter rcmf_checker u_rcmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid)
);
